>>> rtl/mlfq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// MLFQ scheduler package
// Shared codes and control/status bundles for the feedback queue scheduler.
// ----------------------------------------------------------------------------
package mlfq_pkg;

    typedef enum logic {
        OP_ADD  = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        STS_ACCEPTED  = 3'd0,
        STS_REFUSED   = 3'd1,
        STS_IDLE_TICK = 3'd2,
        STS_RAN       = 3'd3,
        STS_DONE      = 3'd4
    } status_t;

    typedef enum logic {
        FSM_IDLE,
        FSM_EXEC
    } fsm_t;

    typedef struct packed {
        logic load_add;
        logic load_idle;
        logic start_run;
        logic finish_run;
        logic pop;
    } mlfq_cmd_t;

    typedef struct packed {
        logic out_valid;
        logic found;
    } mlfq_stat_t;

endpackage
`default_nettype wire

>>> rtl/mlfq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// MLFQ generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mlfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

>>> rtl/mlfq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// MLFQ controller
// Sequences add, idle-tick and run-tick items; a run tick passes through EXEC.
// ----------------------------------------------------------------------------
module mlfq_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    input  wire logic                s_op,
    input  wire logic                m_tready,
    input  wire mlfq_pkg::mlfq_stat_t stat,
    output logic                     s_tready,
    output mlfq_pkg::mlfq_cmd_t      cmd
);
    import mlfq_pkg::*;

    fsm_t state_reg, state_next;
    logic s_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        s_tready       = 1'b0;
        cmd            = '0;
        cmd.pop        = stat.out_valid & m_tready;
        s_fire         = 1'b0;
        case (state_reg)
            FSM_IDLE:
            begin
                s_tready = ~stat.out_valid | m_tready;
                s_fire   = s_tready & s_tvalid;
                if (s_fire)
                begin
                    if (s_op == OP_ADD)
                    begin
                        cmd.load_add = 1'b1;
                    end
                    else if (!stat.found)
                    begin
                        cmd.load_idle = 1'b1;
                    end
                    else
                    begin
                        cmd.start_run = 1'b1;
                        state_next    = FSM_EXEC;
                    end
                end
            end
            FSM_EXEC:
            begin
                cmd.finish_run = 1'b1;
                state_next     = FSM_IDLE;
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/mlfq_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// MLFQ datapath
// Level queue pointers, process store, time counter and result register.
// ----------------------------------------------------------------------------
module mlfq_dp #(
    parameter int MAX_LEVELS  = 4,
    parameter int QUEUE_DEPTH = 16,
    parameter int TIME_BITS   = 16,
    localparam int LW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire mlfq_pkg::mlfq_cmd_t  cmd,
    output mlfq_pkg::mlfq_stat_t      stat,
    input  wire logic                 cfg_we,
    input  wire logic [2:0]           cfg_data,
    input  wire logic [7:0]           in_id,
    input  wire logic [TIME_BITS-1:0] in_arrival,
    input  wire logic [TIME_BITS-1:0] in_burst,
    output logic [2:0]                o_status,
    output logic [7:0]                o_ran_id,
    output logic [LW-1:0]             o_ran_level,
    output logic [TIME_BITS-1:0]      o_first_run,
    output logic [TIME_BITS-1:0]      o_finish,
    output logic signed [TIME_BITS:0] o_turnaround,
    output logic signed [TIME_BITS:0] o_waiting,
    output logic signed [TIME_BITS:0] o_response,
    output logic [TIME_BITS-1:0]      o_now
);
    import mlfq_pkg::*;

    localparam int TB    = TIME_BITS;
    localparam int NSLOT = MAX_LEVELS * QUEUE_DEPTH;
    localparam int AW    = $clog2(NSLOT);
    localparam int PW    = $clog2(QUEUE_DEPTH);
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int EW    = 8 + 4 * TB + 1;
    localparam logic [3:0] ML4 = 4'(MAX_LEVELS);
    localparam logic [TB-1:0] TMAX = {TB{1'b1}};
    localparam logic signed [TB+1:0] WMAX = {2'b00, {TB{1'b1}}};
    localparam logic signed [TB+1:0] WMIN = -WMAX;

    typedef struct packed {
        logic          started;
        logic [TB-1:0] first;
        logic [TB-1:0] left;
        logic [TB-1:0] burst;
        logic [TB-1:0] arrival;
        logic [7:0]    id;
    } entry_t;

    logic [PW-1:0] head_reg  [MAX_LEVELS];
    logic [PW-1:0] tail_reg  [MAX_LEVELS];
    logic [CW-1:0] count_reg [MAX_LEVELS];
    logic [CW-1:0] total_reg;
    logic [TB-1:0] time_reg;
    logic [TB-1:0] now_reg;
    logic [LW-1:0] lvl_reg;
    logic [2:0]    levels_reg;
    logic          out_valid_reg;

    logic [2:0]         status_reg;
    logic [7:0]         id_reg;
    logic [LW-1:0]      olvl_reg;
    logic [TB-1:0]      first_reg;
    logic [TB-1:0]      fin_reg;
    logic signed [TB:0] tat_reg;
    logic signed [TB:0] wait_reg;
    logic signed [TB:0] resp_reg;
    logic [TB-1:0]      onow_reg;

    logic          found;
    logic [LW-1:0] found_lvl;
    logic [3:0]    eff;
    logic [3:0]    nxt_lvl;
    logic [LW-1:0] dem_lvl;
    logic          refuse;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    entry_t        mem_wdata;
    logic [AW-1:0] rd_addr;
    logic [EW-1:0] rdata_raw;
    entry_t        ent;
    logic [TB-1:0] first_v;
    logic [TB-1:0] left_v;
    logic          done;
    logic          demote;
    logic [TB-1:0] fin_v;
    logic signed [TB:0]   tat_v;
    logic signed [TB+1:0] wfull;
    logic signed [TB:0]   wait_v;
    logic signed [TB:0]   resp_v;
    logic [TB-1:0] time_inc;

    function automatic logic [PW-1:0] next_pos(input logic [PW-1:0] p);
        next_pos = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_comb
    begin
        found     = 1'b0;
        found_lvl = '0;
        for (int l = MAX_LEVELS - 1; l >= 0; l--)
        begin
            if (count_reg[l] != '0)
            begin
                found     = 1'b1;
                found_lvl = LW'(l);
            end
        end
    end

    assign stat.found     = found;
    assign stat.out_valid = out_valid_reg;

    assign eff = (levels_reg == 3'd0) ? 4'd1 :
                 ({1'b0, levels_reg} > ML4) ? ML4 : {1'b0, levels_reg};
    assign rd_addr = AW'(found_lvl) * AW'(QUEUE_DEPTH) + AW'(head_reg[found_lvl]);
    assign refuse  = (total_reg >= CW'(QUEUE_DEPTH)) || (in_burst == '0);

    assign ent      = entry_t'(rdata_raw);
    assign first_v  = ent.started ? ent.first : now_reg;
    assign left_v   = ent.left - TB'(1);
    assign done     = (left_v == '0);
    assign nxt_lvl  = 4'(lvl_reg) + 4'd1;
    assign dem_lvl  = LW'(nxt_lvl);
    assign demote   = !done && (nxt_lvl < eff);
    assign fin_v    = (now_reg == TMAX) ? TMAX : now_reg + TB'(1);
    assign tat_v    = $signed({1'b0, fin_v}) - $signed({1'b0, ent.arrival});
    assign wfull    = $signed({tat_v[TB], tat_v}) - $signed({2'b00, ent.burst});
    assign wait_v   = (wfull > WMAX) ? WMAX[TB:0] :
                      (wfull < WMIN) ? WMIN[TB:0] : wfull[TB:0];
    assign resp_v   = $signed({1'b0, first_v}) - $signed({1'b0, ent.arrival});
    assign time_inc = (time_reg == TMAX) ? TMAX : time_reg + TB'(1);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        if (cmd.load_add)
        begin
            mem_we            = !refuse;
            mem_waddr         = AW'(tail_reg[0]);
            mem_wdata.id      = in_id;
            mem_wdata.arrival = in_arrival;
            mem_wdata.burst   = in_burst;
            mem_wdata.left    = in_burst;
        end
        else if (cmd.finish_run)
        begin
            mem_we            = !done;
            mem_wdata         = ent;
            mem_wdata.left    = left_v;
            mem_wdata.first   = first_v;
            mem_wdata.started = 1'b1;
            if (demote)
            begin
                mem_waddr = AW'(dem_lvl) * AW'(QUEUE_DEPTH) + AW'(tail_reg[dem_lvl]);
            end
            else
            begin
                mem_waddr = AW'(lvl_reg) * AW'(QUEUE_DEPTH) + AW'(head_reg[lvl_reg]);
            end
        end
    end

    mlfq_ram #(
        .WIDTH (EW),
        .DEPTH (NSLOT)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (EW'(mem_wdata)),
        .re    (cmd.start_run),
        .raddr (rd_addr),
        .rdata (rdata_raw)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < MAX_LEVELS; l++)
            begin
                head_reg[l]  <= '0;
                tail_reg[l]  <= '0;
                count_reg[l] <= '0;
            end
            total_reg     <= '0;
            time_reg      <= '0;
            levels_reg    <= 3'd3;
            out_valid_reg <= 1'b0;
            now_reg       <= '0;
            lvl_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                levels_reg <= cfg_data;
            end
            if (cmd.pop)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.load_add || cmd.load_idle || cmd.finish_run)
            begin
                out_valid_reg <= 1'b1;
            end
            if (cmd.load_add && !refuse)
            begin
                tail_reg[0]  <= next_pos(tail_reg[0]);
                count_reg[0] <= count_reg[0] + CW'(1);
                total_reg    <= total_reg + CW'(1);
            end
            if (cmd.load_idle || cmd.start_run)
            begin
                time_reg <= time_inc;
            end
            if (cmd.start_run)
            begin
                now_reg <= time_reg;
                lvl_reg <= found_lvl;
            end
            if (cmd.finish_run)
            begin
                if (done)
                begin
                    head_reg[lvl_reg]  <= next_pos(head_reg[lvl_reg]);
                    count_reg[lvl_reg] <= count_reg[lvl_reg] - CW'(1);
                    total_reg          <= total_reg - CW'(1);
                end
                else if (demote)
                begin
                    head_reg[lvl_reg]  <= next_pos(head_reg[lvl_reg]);
                    count_reg[lvl_reg] <= count_reg[lvl_reg] - CW'(1);
                    tail_reg[dem_lvl]  <= next_pos(tail_reg[dem_lvl]);
                    count_reg[dem_lvl] <= count_reg[dem_lvl] + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_add || cmd.load_idle)
        begin
            status_reg <= cmd.load_add ? (refuse ? STS_REFUSED : STS_ACCEPTED)
                                       : STS_IDLE_TICK;
            id_reg     <= '0;
            olvl_reg   <= '0;
            first_reg  <= '0;
            fin_reg    <= '0;
            tat_reg    <= '0;
            wait_reg   <= '0;
            resp_reg   <= '0;
            onow_reg   <= time_reg;
        end
        else if (cmd.finish_run)
        begin
            status_reg <= done ? STS_DONE : STS_RAN;
            id_reg     <= ent.id;
            olvl_reg   <= lvl_reg;
            first_reg  <= first_v;
            fin_reg    <= done ? fin_v : '0;
            tat_reg    <= done ? tat_v : '0;
            wait_reg   <= done ? wait_v : '0;
            resp_reg   <= done ? resp_v : '0;
            onow_reg   <= now_reg;
        end
    end

    assign o_status     = status_reg;
    assign o_ran_id     = id_reg;
    assign o_ran_level  = olvl_reg;
    assign o_first_run  = first_reg;
    assign o_finish     = fin_reg;
    assign o_turnaround = tat_reg;
    assign o_waiting    = wait_reg;
    assign o_response   = resp_reg;
    assign o_now        = onow_reg;

endmodule
`default_nettype wire

>>> rtl/multilevel_feedback_queue_scheduler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Multilevel feedback queue scheduler
// Stream-in add/tick items, stream-out one result per item.
// ----------------------------------------------------------------------------
// Input stream s_*: s_tuser is the op (0 add, 1 tick); s_tdata carries proc_id,
// arrival and burst. Output stream m_*: m_tuser is the status;
// m_tdata carries ran_id, ran_level, first_run_time, finish_time, turnaround,
// waiting, response and now. Every input transfer yields exactly one result.
// An add or an idle tick has its result registered at the transfer edge.
// A tick that runs a process first reads the head entry from the process
// store RAM, then in the EXEC state updates it and writes it back, moves it
// to the next level or retires it when done. Adds and idle ticks go at one
// item per cycle while results are taken; no new item is accepted in EXEC.
// The result register holds until m_tready; s_tready stays low while a held
// result is not being taken, so a stalled receiver stalls the input.
// Reset clears the level pointers, counts and time, and sets levels_in_use
// to 3; the store needs no clearing. cfg_* writes levels_in_use, always ready;
// write it only while the block is idle.
// ----------------------------------------------------------------------------
module multilevel_feedback_queue_scheduler #(
    parameter int MAX_LEVELS  = 4,
    parameter int QUEUE_DEPTH = 16,
    parameter int TIME_BITS   = 16,
    localparam int LW      = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1,
    localparam int IN_DW   = ((8 + 2 * TIME_BITS + 7) / 8) * 8,
    localparam int OUT_RAW = 8 + LW + 3 * TIME_BITS + 3 * (TIME_BITS + 1),
    localparam int OUT_DW  = ((OUT_RAW + 7) / 8) * 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [2:0]        cfg_data,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [IN_DW-1:0]  s_tdata,   // proc_id, arrival, burst
    input  wire logic              s_tuser,   // op
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [OUT_DW-1:0]      m_tdata,   // ran_id, ran_level, first_run_time,
                                              // finish_time, turnaround, waiting,
                                              // response, now
    output logic [2:0]             m_tuser    // status
);
    import mlfq_pkg::*;

    localparam int TB = TIME_BITS;

    mlfq_cmd_t  cmd;
    mlfq_stat_t stat;

    logic [7:0]         ran_id;
    logic [LW-1:0]      ran_level;
    logic [TB-1:0]      first_run;
    logic [TB-1:0]      finish;
    logic signed [TB:0] turnaround;
    logic signed [TB:0] waiting;
    logic signed [TB:0] response;
    logic [TB-1:0]      now;

    assign cfg_ready = 1'b1;

    mlfq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_op     (s_tuser),
        .m_tready (m_tready),
        .stat     (stat),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    mlfq_dp #(
        .MAX_LEVELS  (MAX_LEVELS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TIME_BITS   (TIME_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_we       (cfg_valid),
        .cfg_data     (cfg_data),
        .in_id        (s_tdata[7:0]),
        .in_arrival   (s_tdata[8+TB-1:8]),
        .in_burst     (s_tdata[8+2*TB-1:8+TB]),
        .o_status     (m_tuser),
        .o_ran_id     (ran_id),
        .o_ran_level  (ran_level),
        .o_first_run  (first_run),
        .o_finish     (finish),
        .o_turnaround (turnaround),
        .o_waiting    (waiting),
        .o_response   (response),
        .o_now        (now)
    );

    assign m_tvalid = stat.out_valid;
    assign m_tdata  = OUT_DW'({now, response, waiting, turnaround, finish, first_run,
                               ran_level, ran_id});

endmodule
`default_nettype wire

>>> rtl/mlfq_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// MLFQ port checker
// Watches the scheduler's ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
module mlfq_chk (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       cfg_ready,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       s_tuser,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [2:0] m_tuser
);
    import mlfq_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tuser))
        else $error("result dropped or changed while stalled");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready && m_tvalid |-> m_tready)
        else $error("input taken while a held result is stalled");

    a_add_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == OP_ADD) |=>
            m_tvalid && (m_tuser == STS_ACCEPTED || m_tuser == STS_REFUSED))
        else $error("add transfer gave no add result");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind multilevel_feedback_queue_scheduler mlfq_chk u_mlfq_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_ready (cfg_ready),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tuser   (m_tuser)
);
`default_nettype wire
